[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AST_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define AST_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/vuq_pkg.sv]
// ----------------------------------------------------------------------------
// vuq_pkg
// Types and constants of the video-memory update queue.
// ----------------------------------------------------------------------------
package vuq_pkg;

  localparam logic [1:0] REQ_RAW   = 2'd0;
  localparam logic [1:0] REQ_TILE  = 2'd1;
  localparam logic [1:0] REQ_ATTR  = 2'd2;
  localparam logic [1:0] REQ_FLUSH = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FULL  = 1'b1;

  localparam logic [15:0] NT_BASE   = 16'h2000;
  localparam logic [15:0] ATTR_BASE = 16'h23C0;
  localparam logic [7:0]  PAL_MASK  = 8'h03;

  localparam int SHADOW_DEPTH = 256;
  localparam int SHADOW_AW    = 8;
  localparam int ENTRY_W      = 24;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] target_addr;
    logic [7:0]  data_byte;
    logic [1:0]  table_sel;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [1:0]  pal_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        last_flag;
  } out_item_t;

  typedef struct packed {
    logic cap;
    logic push_direct;
    logic push_attr;
    logic attr_rd;
    logic attr_wr;
    logic flush_rd;
    logic fl_adv;
    logic cnt_clr;
    logic out_load_data;
    logic out_load_full;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic fl_last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/vuq_ram.sv]
// ----------------------------------------------------------------------------
// vuq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vuq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[rtl/vuq_ctrl.sv]
// ----------------------------------------------------------------------------
// vuq_ctrl
// Sequencer: accepts requests, steps attribute updates and flush streaming.
// ----------------------------------------------------------------------------
module vuq_ctrl import vuq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  input  dp_stat_t   stat,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ATTR = 2'd1;
  localparam logic [1:0] ST_FRD  = 2'd2;
  localparam logic [1:0] ST_FLD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        // hold a push that would be refused until the result register frees
        in_stall = (req_type != REQ_FLUSH) && stat.full && !stat.out_free;
        if (in_valid && !in_stall) begin
          case (req_type)
            REQ_FLUSH: begin
              if (!stat.empty) begin
                state_nxt = ST_FRD;
              end
            end
            default: begin
              if (stat.full) begin
                cmd.out_load_full = 1'b1;
              end else if (req_type == REQ_ATTR) begin
                cmd.cap     = 1'b1;
                cmd.attr_rd = 1'b1;
                state_nxt   = ST_ATTR;
              end else begin
                cmd.push_direct = 1'b1;
              end
            end
          endcase
        end
      end
      ST_ATTR: begin
        cmd.attr_wr   = 1'b1;
        cmd.push_attr = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_FRD: begin
        cmd.flush_rd = 1'b1;
        state_nxt    = ST_FLD;
      end
      ST_FLD: begin
        if (stat.out_free) begin
          cmd.out_load_data = 1'b1;
          if (stat.fl_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            cmd.fl_adv = 1'b1;
            state_nxt  = ST_FRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/vuq_dp.sv]
// ----------------------------------------------------------------------------
// vuq_dp
// Datapath: write queue, shadow attribute store, address math, result register.
// ----------------------------------------------------------------------------
module vuq_dp import vuq_pkg::*; #(
  parameter int QUEUE_DEPTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [CW-1:0]          fl_r;
  logic [CW-1:0]          fl_nxt;
  in_item_t               req_r;
  logic [SHADOW_DEPTH-1:0] shv_r;
  logic                   sh_vld_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_item_t              out_item_r;
  out_item_t              out_item_nxt;

  logic [15:0]            tile_addr;
  logic [15:0]            direct_addr;
  logic [5:0]             attr_cell;
  logic [15:0]            attr_addr;
  logic [2:0]             shift;
  logic [7:0]             mask;
  logic [7:0]             old_byte;
  logic [7:0]             new_byte;
  logic [SHADOW_AW-1:0]   sh_raddr;
  logic [SHADOW_AW-1:0]   sh_waddr;
  logic [7:0]             sh_rdata;
  logic                   q_we;
  logic [ENTRY_W-1:0]     q_wdata;
  logic [ENTRY_W-1:0]     q_rdata;

  // Address math
  assign tile_addr = NT_BASE + {4'd0, in_item.table_sel, 10'd0}
                   + {6'd0, in_item.cell_y, 5'd0} + {11'd0, in_item.cell_x};
  assign direct_addr = (in_item.req_type == REQ_RAW) ? in_item.target_addr : tile_addr;

  assign attr_cell = {req_r.cell_y[4:2], req_r.cell_x[4:2]};
  assign attr_addr = ATTR_BASE + {4'd0, req_r.table_sel, 10'd0} + {10'd0, attr_cell};
  assign shift     = {req_r.cell_y[1], req_r.cell_x[1], 1'b0};
  assign mask      = PAL_MASK << shift;
  // an entry never written reads as zero
  assign old_byte  = sh_vld_r ? sh_rdata : 8'h00;
  assign new_byte  = (old_byte & ~mask) | ({6'd0, req_r.pal_index} << shift);

  assign sh_raddr = {in_item.table_sel, in_item.cell_y[4:2], in_item.cell_x[4:2]};
  assign sh_waddr = {req_r.table_sel, attr_cell};

  vuq_ram #(
    .WIDTH (8),
    .DEPTH (SHADOW_DEPTH)
  ) u_shadow (
    .clk     (clk),
    .we      (cmd.attr_wr),
    .waddr   (sh_waddr),
    .wdata   (new_byte),
    .re      (cmd.attr_rd),
    .raddr   (sh_raddr),
    .rdata_r (sh_rdata)
  );

  // Write queue
  assign q_we    = cmd.push_direct || cmd.push_attr;
  assign q_wdata = cmd.push_attr ? {attr_addr, new_byte} : {direct_addr, in_item.data_byte};

  vuq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .we      (q_we),
    .waddr   (count_r[AW-1:0]),
    .wdata   (q_wdata),
    .re      (cmd.flush_rd),
    .raddr   (fl_r[AW-1:0]),
    .rdata_r (q_rdata)
  );

  always_comb begin
    count_nxt = count_r;
    fl_nxt    = fl_r;
    if (cmd.cnt_clr) begin
      count_nxt = '0;
      fl_nxt    = '0;
    end else begin
      if (q_we) begin
        count_nxt = count_r + CW'(1);
      end
      if (cmd.fl_adv) begin
        fl_nxt = fl_r + CW'(1);
      end
    end
  end

  assign stat.full     = (count_r >= DEPTH_C);
  assign stat.empty    = (count_r == '0);
  assign stat.fl_last  = ((fl_r + CW'(1)) == count_r);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (cmd.out_load_full) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.result_kind = KIND_FULL;
      out_item_nxt.write_addr  = '0;
      out_item_nxt.write_data  = '0;
      out_item_nxt.last_flag   = 1'b1;
    end else if (cmd.out_load_data) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.result_kind = KIND_WRITE;
      out_item_nxt.write_addr  = q_rdata[ENTRY_W-1:8];
      out_item_nxt.write_data  = q_rdata[7:0];
      out_item_nxt.last_flag   = stat.fl_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fl_r        <= '0;
      shv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      fl_r        <= fl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.attr_wr) begin
        shv_r[sh_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.cap) begin
      req_r <= in_item;
    end
    if (cmd.attr_rd) begin
      sh_vld_r <= shv_r[sh_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/vram_update_queue_unit.sv]
// ----------------------------------------------------------------------------
// vram_update_queue_unit
// Deferred video-memory write queue with a shadow attribute store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_item carries one request per transfer:
//   raw write, tile write, attribute write or flush. Result channel
//   out_valid/out_stall/out_item carries emitted writes and full refusals.
//   Raw and tile writes give no result. An attribute write first reads the
//   shadow store, then merges the palette field and queues the byte. A push
//   into a full queue gives one refusal result, visible the cycle after the
//   transfer. A flush of N queued writes streams N results (queue RAM
//   read, then load of the result register, which waits while a held
//   result is stalled); the last carries last_flag.
//   The input is stalled during attribute updates and flush streaming.
//   Reset empties the queue and marks every shadow attribute byte as zero
//   through per-entry valid bits; no clearing pass is needed.
//   While out_stall is high over a valid result the result register holds;
//   the flush waits and a push that would be refused is stalled, other pushes are still taken.
// ----------------------------------------------------------------------------
module vram_update_queue_unit import vuq_pkg::*; #(
  parameter int QUEUE_DEPTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  vuq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_item.req_type),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  vuq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[rtl/vuq_checker.sv]
// ----------------------------------------------------------------------------
// vuq_checker
// Port-level checks of the video-memory update queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vuq_checker import vuq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `AST_ON(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `AST_ON(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_item))
  `AST_ON(a_full_shape, clk, rst_n, out_valid && (out_item.result_kind == KIND_FULL) |-> out_item.last_flag && (out_item.write_addr == 16'd0) && (out_item.write_data == 8'd0))
  `AST_ON(a_flush_busy, clk, rst_n, out_valid && !out_item.last_flag |-> in_stall)
  `AST_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind vram_update_queue_unit vuq_checker u_vuq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the video-memory update queue: raw, tile and attribute pushes,
// flush streaming, and refusals on a full queue. A behavioral copy of the
// queue and the shadow attribute store predicts every result, and each
// result transfer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import vuq_pkg::*;

  localparam int DEPTH       = 24;
  localparam int PHASE_ITEMS = 100;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 600000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t    pending_reqs[$];
  out_item_t   predicted_writes[$];
  logic [15:0] queued_addr[DEPTH];
  logic [7:0]  queued_data[DEPTH];
  int          queued_count = 0;
  logic [7:0]  attr_copy[256];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic in_took       = 1'b0;
  int   err_count     = 0;
  int   cycle_count   = 0;

  vram_update_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (err_count < 40) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    err_count++;
  endtask

  // Update the queue copy and shadow store for one accepted request.
  task automatic apply_request(input in_item_t req);
    logic [5:0]  attr_ofs;
    logic [2:0]  shift;
    logic [7:0]  mask;
    logic [7:0]  idx;
    logic [7:0]  merged;
    out_item_t   res;
    if (req.req_type == REQ_FLUSH) begin
      for (int i = 0; i < queued_count; i++) begin
        res.result_kind = KIND_WRITE;
        res.write_addr  = queued_addr[i];
        res.write_data  = queued_data[i];
        res.last_flag   = (i == queued_count - 1);
        predicted_writes.push_back(res);
      end
      queued_count = 0;
    end else if (queued_count >= DEPTH) begin
      // refused push leaves every piece of state alone
      res             = '0;
      res.result_kind = KIND_FULL;
      res.last_flag   = 1'b1;
      predicted_writes.push_back(res);
    end else begin
      case (req.req_type)
        REQ_RAW: begin
          queued_addr[queued_count] = req.target_addr;
          queued_data[queued_count] = req.data_byte;
        end
        REQ_TILE: begin
          queued_addr[queued_count] = NT_BASE + {4'b0, req.table_sel, 10'b0}
                                      + {6'b0, req.cell_y, 5'b0} + {11'b0, req.cell_x};
          queued_data[queued_count] = req.data_byte;
        end
        default: begin
          attr_ofs = {req.cell_y[4:2], req.cell_x[4:2]};
          shift    = {req.cell_y[1], req.cell_x[1], 1'b0};
          mask     = PAL_MASK << shift;
          idx      = {req.table_sel, attr_ofs};
          merged   = (attr_copy[idx] & ~mask) | ({6'b0, req.pal_index} << shift);
          attr_copy[idx] = merged;
          queued_addr[queued_count] = ATTR_BASE + {4'b0, req.table_sel, 10'b0}
                                      + {10'b0, attr_ofs};
          queued_data[queued_count] = merged;
        end
      endcase
      queued_count++;
    end
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        apply_request(in_item);
      end
      if (out_valid && !out_stall) begin
        if (predicted_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_item));
        end else begin
          want = predicted_writes.pop_front();
          if (out_item.result_kind !== want.result_kind) begin
            report_mismatch($sformatf("result_kind got %b want %b",
                                      out_item.result_kind, want.result_kind));
          end
          if (out_item.write_addr !== want.write_addr) begin
            report_mismatch($sformatf("write_addr got %h want %h",
                                      out_item.write_addr, want.write_addr));
          end
          if (out_item.write_data !== want.write_data) begin
            report_mismatch($sformatf("write_data got %h want %h",
                                      out_item.write_data, want.write_data));
          end
          if (out_item.last_flag !== want.last_flag) begin
            report_mismatch($sformatf("last_flag got %b want %b",
                                      out_item.last_flag, want.last_flag));
          end
        end
      end
    end else begin
      in_took <= 1'b0;
    end
  end

  // Drive at the falling edge; hold the payload until its transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t make_req(input logic [1:0] kind, input logic [15:0] addr,
                                        input logic [7:0] data, input logic [1:0] tbl,
                                        input logic [4:0] x, input logic [4:0] y,
                                        input logic [1:0] pal);
    in_item_t r;
    r.req_type    = kind;
    r.target_addr = addr;
    r.data_byte   = data;
    r.table_sel   = tbl;
    r.cell_x      = x;
    r.cell_y      = y;
    r.pal_index   = pal;
    return r;
  endfunction

  function automatic in_item_t random_req(input logic [1:0] kind);
    in_item_t r;
    r = make_req(kind, 16'($urandom), 8'($urandom), 2'($urandom_range(3)),
                 5'($urandom_range(31)), 5'($urandom_range(31)), 2'($urandom_range(3)));
    // crowd attribute writes onto few bytes so the merges stack up
    if (kind == REQ_ATTR && $urandom_range(1) == 1) begin
      r.table_sel = 2'($urandom_range(1));
      r.cell_x    = 5'($urandom_range(7));
      r.cell_y    = 5'($urandom_range(7));
    end
    return r;
  endfunction

  task automatic add_burst(input int n);
    logic [1:0] kind;
    for (int i = 0; i < n; i++) begin
      kind = 2'($urandom_range(2));
      pending_reqs.push_back(random_req(kind));
    end
    pending_reqs.push_back(random_req(REQ_FLUSH));
  endtask

  // Mostly push bursts closed by a flush, some of them past full; the rest
  // is lone requests of any type.
  task automatic add_phase(input int items);
    int added;
    int n;
    added = 0;
    while (added < items) begin
      if ($urandom_range(99) < 15) begin
        pending_reqs.push_back(random_req(2'($urandom_range(3))));
        added++;
      end else begin
        n = ($urandom_range(4) == 0) ? $urandom_range(30, 25) : $urandom_range(23);
        add_burst(n);
        added += n + 1;
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || predicted_writes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      attr_copy[i] = '0;
    end
    send_idle_pct = 34;
    recv_idle_pct = 68;

    pending_reqs.push_back(make_req(REQ_FLUSH, 16'hFFFF, 8'hFF, 2'd3, 5'd31, 5'd31, 2'd3));
    pending_reqs.push_back(make_req(REQ_RAW, 16'h0000, 8'h00, 2'd0, 5'd0, 5'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_RAW, 16'hFFFF, 8'hFF, 2'd3, 5'd31, 5'd31, 2'd3));
    pending_reqs.push_back(make_req(REQ_TILE, 16'h0000, 8'h00, 2'd0, 5'd0, 5'd0, 2'd0));
    pending_reqs.push_back(make_req(REQ_TILE, 16'h1234, 8'hFF, 2'd3, 5'd31, 5'd31, 2'd1));
    pending_reqs.push_back(make_req(REQ_TILE, 16'h0000, 8'h5A, 2'd1, 5'd31, 5'd29, 2'd0));
    // all four fields of one attribute byte, then clear one again
    pending_reqs.push_back(make_req(REQ_ATTR, 16'h0000, 8'h00, 2'd0, 5'd0, 5'd0, 2'd3));
    pending_reqs.push_back(make_req(REQ_ATTR, 16'h0000, 8'h00, 2'd0, 5'd2, 5'd0, 2'd1));
    pending_reqs.push_back(make_req(REQ_ATTR, 16'h0000, 8'h00, 2'd0, 5'd0, 5'd2, 2'd2));
    pending_reqs.push_back(make_req(REQ_ATTR, 16'h0000, 8'h00, 2'd0, 5'd3, 5'd3, 2'd3));
    pending_reqs.push_back(make_req(REQ_ATTR, 16'hFFFF, 8'hFF, 2'd3, 5'd31, 5'd31, 2'd3));
    pending_reqs.push_back(make_req(REQ_ATTR, 16'h0000, 8'h00, 2'd0, 5'd1, 5'd1, 2'd0));
    pending_reqs.push_back(make_req(REQ_ATTR, 16'h0000, 8'h00, 2'd2, 5'd16, 5'd30, 2'd2));
    pending_reqs.push_back(make_req(REQ_FLUSH, 16'h0000, 8'h00, 2'd0, 5'd0, 5'd0, 2'd0));
    // overfill right away so pushes meet a full queue early
    add_burst(29);
    add_phase(PHASE_ITEMS);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();

    send_idle_pct = 68;
    recv_idle_pct = 34;
    add_phase(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_phase(PHASE_ITEMS);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && predicted_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/vuq_pkg.sv
rtl/vuq_ram.sv
rtl/vuq_ctrl.sv
rtl/vuq_dp.sv
rtl/vram_update_queue_unit.sv
rtl/vuq_checker.sv
tb/sv/testbench.sv
